### src/tcw_pkg.sv
// Text console writer: shared types and constants.
// Used by the top level and by anything that drives or watches its channels.
// No dependencies.
package tcw_pkg;

	localparam int FUNC_W  = 2;
	localparam int CHAR_W  = 8;
	localparam int ATTR_W  = 8;
	localparam int ROWSEL_W = 5;
	localparam int COLSEL_W = 7;
	localparam int CROW_W  = 5;
	localparam int CCOL_W  = 7;
	localparam int LOC_W   = 11;
	localparam int TAB_W   = 7;
	localparam int CELL_W  = CHAR_W + ATTR_W;

	localparam logic [FUNC_W-1:0] FN_PUT   = 2'd0;
	localparam logic [FUNC_W-1:0] FN_SET   = 2'd1;
	localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd2;
	localparam logic [FUNC_W-1:0] FN_READ  = 2'd3;

	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;

	// char 0, white on black
	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F00;
	localparam logic [TAB_W-1:0]  TAB_RESET  = 7'd4;

	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic [CHAR_W-1:0]   char_code;
		logic [ATTR_W-1:0]   attr;
		logic [ROWSEL_W-1:0] row_sel;
		logic [COLSEL_W-1:0] col_sel;
	} cmd_t;

	typedef struct packed {
		logic [CROW_W-1:0] cursor_row;
		logic [CCOL_W-1:0] cursor_col;
		logic [LOC_W-1:0]  cursor_location;
		logic              scrolled;
		logic [CHAR_W-1:0] read_char;
		logic [ATTR_W-1:0] read_attr;
	} rsp_t;

endpackage

### src/tcw_chan_if.sv
// Valid/ready channel carrying one payload beat.
// Payload type is set at instantiation; no other dependencies.
interface tcw_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### src/text_console_writer_top.sv
// Text console writer top level: command sequencer around the cell RAM.
// Depends on tcw_pkg, tcw_chan_if and tcw_ram.
//
// One command beat on cmd gives exactly one beat on rsp; commands are handled one at a
// time, and the next is taken while the previous response still waits on rsp. After
// reset a clearing pass writes every cell, during which cmd is not ready; cfg is always
// ready. All cell writes share the RAM's single write port. A tab subtracts COLUMNS
// from the new column one step at a time. A put that runs off the bottom adds a scroll
// pass (one cell moved per cycle), and clear screen reruns the clearing pass.
module text_console_writer_top #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	tcw_chan_if.sink    cmd,
	tcw_chan_if.source  rsp,
	tcw_chan_if.sink    cfg
);
	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int RXW   = $clog2(ROWS + 2);
	localparam int CAW   = $clog2(COLUMNS + 128);

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_TAB    = 4'd2;
	localparam logic [3:0] ST_CHK    = 4'd3;
	localparam logic [3:0] ST_SCROLL = 4'd4;
	localparam logic [3:0] ST_DRAIN  = 4'd5;
	localparam logic [3:0] ST_PRINT  = 4'd6;
	localparam logic [3:0] ST_RDREQ  = 4'd7;
	localparam logic [3:0] ST_RDWAIT = 4'd8;
	localparam logic [3:0] ST_DONE   = 4'd9;

	logic [3:0]                 state_q;
	tcw_pkg::cmd_t              cmd_q;
	logic                       print_q;
	logic                       wrap_q;
	logic                       scrolled_q;
	logic                       resp_due_q;
	logic [tcw_pkg::CELL_W-1:0] rd_q;
	logic [RXW-1:0]             cur_row_q;
	logic [CW-1:0]              cur_col_q;
	logic [CAW-1:0]             col_acc_q;
	logic [AW-1:0]              cnt_q;
	logic [tcw_pkg::TAB_W-1:0]  tab_q;
	logic                       v_s1;
	logic                       wsel_s1;
	logic [AW-1:0]              wa_s1;
	tcw_pkg::rsp_t              rsp_q;
	logic                       rsp_v_q;

	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [tcw_pkg::CELL_W-1:0] ram_wdata;
	logic [AW-1:0]              ram_raddr;
	logic [tcw_pkg::CELL_W-1:0] ram_rdata;

	logic cnt_last;
	logic rd_in_range;
	logic rsp_free;
	logic [AW-1:0] cur_addr;
	logic [AW-1:0] sel_addr;

	assign cnt_last    = (cnt_q == AW'(CELLS - 1));
	assign rd_in_range = (int'(cmd_q.row_sel) < ROWS) && (int'(cmd_q.col_sel) < COLUMNS);
	assign rsp_free    = !rsp_v_q || rsp.ready;
	assign cur_addr    = AW'(cur_row_q) * AW'(COLUMNS) + AW'(cur_col_q);
	assign sel_addr    = AW'(cmd_q.row_sel) * AW'(COLUMNS) + AW'(cmd_q.col_sel);

	assign cmd.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_v_q;
	assign rsp.data  = rsp_q;

	// single write port: sweep clear, scroll copy (written the cycle after its read), print
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_addr;
		ram_wdata = {cmd_q.attr, cmd_q.char_code};
		ram_raddr = sel_addr;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = cnt_q;
			ram_wdata = tcw_pkg::BLANK_CELL;
		end else if (v_s1) begin
			ram_we    = 1'b1;
			ram_waddr = wa_s1;
			ram_wdata = wsel_s1 ? ram_rdata : '0;
		end else if (state_q == ST_PRINT) begin
			ram_we = 1'b1;
		end
		if (state_q == ST_SCROLL) begin
			ram_raddr = cnt_q + AW'(COLUMNS);
		end
	end

	tcw_ram #(
		.WIDTH (tcw_pkg::CELL_W),
		.DEPTH (CELLS)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_q <= tcw_pkg::TAB_RESET;
		end else if (cfg.valid) begin
			tab_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			wsel_s1 <= 1'b0;
			wa_s1   <= '0;
		end else begin
			v_s1    <= (state_q == ST_SCROLL);
			wsel_s1 <= (cnt_q < AW'(CELLS - COLUMNS));
			wa_s1   <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (state_q == ST_DONE && rsp_free) begin
			rsp_v_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			cmd_q      <= '0;
			print_q    <= 1'b0;
			wrap_q     <= 1'b0;
			scrolled_q <= 1'b0;
			resp_due_q <= 1'b0;
			rd_q       <= '0;
			cur_row_q  <= '0;
			cur_col_q  <= '0;
			col_acc_q  <= '0;
			cnt_q      <= '0;
			rsp_q      <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_last) begin
						cnt_q   <= '0;
						state_q <= resp_due_q ? ST_DONE : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd.valid) begin
						cmd_q      <= cmd.data;
						resp_due_q <= 1'b1;
						scrolled_q <= 1'b0;
						rd_q       <= '0;
						print_q    <= 1'b0;
						wrap_q     <= 1'b0;
						case (cmd.data.func)
							tcw_pkg::FN_PUT: begin
								state_q <= ST_CHK;
								case (cmd.data.char_code)
									tcw_pkg::CH_NEWLINE: begin
										cur_row_q <= cur_row_q + 1'b1;
										cur_col_q <= '0;
									end
									tcw_pkg::CH_TAB: begin
										col_acc_q <= CAW'(cur_col_q) + CAW'(tab_q);
										state_q   <= ST_TAB;
									end
									tcw_pkg::CH_BACKSPACE: begin
										if (cur_col_q != '0) begin
											cur_col_q <= cur_col_q - 1'b1;
										end else if (cur_row_q != '0) begin
											cur_row_q <= cur_row_q - 1'b1;
											cur_col_q <= CW'(COLUMNS - 1);
										end
									end
									default: begin
										print_q <= 1'b1;
									end
								endcase
							end
							tcw_pkg::FN_SET: begin
								cur_row_q <= (int'(cmd.data.row_sel) < ROWS) ?
									RXW'(cmd.data.row_sel) : RXW'(ROWS - 1);
								cur_col_q <= (int'(cmd.data.col_sel) < COLUMNS) ?
									CW'(cmd.data.col_sel) : CW'(COLUMNS - 1);
								state_q   <= ST_DONE;
							end
							tcw_pkg::FN_CLEAR: begin
								cur_row_q <= '0;
								cur_col_q <= '0;
								cnt_q     <= '0;
								state_q   <= ST_CLEAR;
							end
							default: begin
								state_q <= ST_RDREQ;
							end
						endcase
					end
				end
				ST_TAB: begin
					// modulo by repeated subtraction; the row moves once only
					if (col_acc_q >= CAW'(COLUMNS)) begin
						col_acc_q <= col_acc_q - CAW'(COLUMNS);
						wrap_q    <= 1'b1;
						if (!wrap_q) begin
							cur_row_q <= cur_row_q + 1'b1;
						end
					end else begin
						cur_col_q <= CW'(col_acc_q);
						state_q   <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (cur_row_q >= RXW'(ROWS)) begin
						cur_row_q  <= RXW'(ROWS - 1);
						scrolled_q <= 1'b1;
						cnt_q      <= '0;
						state_q    <= ST_SCROLL;
					end else begin
						state_q <= print_q ? ST_PRINT : ST_DONE;
					end
				end
				ST_SCROLL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_last) begin
						cnt_q   <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= print_q ? ST_PRINT : ST_DONE;
				end
				ST_PRINT: begin
					if (cur_col_q == CW'(COLUMNS - 1)) begin
						cur_col_q <= '0;
						cur_row_q <= cur_row_q + 1'b1;
					end else begin
						cur_col_q <= cur_col_q + 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_RDREQ: begin
					state_q <= ST_RDWAIT;
				end
				ST_RDWAIT: begin
					if (rd_in_range) begin
						rd_q <= ram_rdata;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_free) begin
						rsp_q.cursor_row      <= tcw_pkg::CROW_W'(cur_row_q);
						rsp_q.cursor_col      <= tcw_pkg::CCOL_W'(cur_col_q);
						rsp_q.cursor_location <= tcw_pkg::LOC_W'(cur_row_q) *
							tcw_pkg::LOC_W'(COLUMNS) + tcw_pkg::LOC_W'(cur_col_q);
						rsp_q.scrolled        <= scrolled_q;
						rsp_q.read_char       <= rd_q[tcw_pkg::CHAR_W-1:0];
						rsp_q.read_attr       <= rd_q[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
						resp_due_q            <= 1'b0;
						state_q               <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	// between commands the cursor is on screen, or one row past it after the last cell
	a_cursor_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> (cur_row_q <= RXW'(ROWS) && cur_col_q <= CW'(COLUMNS - 1)))
		else $error("cursor out of range between commands");

	// the scroll copy must have drained before the print write takes the port
	a_print_port_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PRINT |-> !v_s1)
		else $error("print write collides with scroll copy");

	// set cursor completes without touching the cell store
	a_set_direct: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && cmd.valid && cmd.data.func == tcw_pkg::FN_SET)
		|=> (state_q == ST_DONE && !ram_we))
		else $error("set cursor did not go straight to response");
`endif

endmodule

### src/tcw_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
